// ----- rtl/joint_command_limiter_macros.svh -----
// assertion macros for the joint command limiter
// used by rtl files that check their own logic; clk and rst_n must be in scope
`ifndef JOINT_COMMAND_LIMITER_MACROS_SVH
`define JOINT_COMMAND_LIMITER_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, disabled during reset
`define JCL_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("joint_command_limiter assertion failed");

// next-cycle implication, disabled during reset
`define JCL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("joint_command_limiter assertion failed");

`else

`define JCL_ASSERT_IMPL(label, ante, cons)
`define JCL_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ----- rtl/jcl_pkg.sv -----
// shared types, constants and helpers for the joint command limiter
// no dependencies; imported by every rtl module of the block
package jcl_pkg;

    localparam int DATA_WIDTH      = 24;
    localparam int MAG_WIDTH       = DATA_WIDTH - 1;
    localparam int APB_DATA_WIDTH  = (DATA_WIDTH > 32) ? 64 : 32;
    localparam int REG_ADDR_LSB    = (DATA_WIDTH > 32) ? 3 : 2;
    localparam int REG_INDEX_WIDTH = 3;
    localparam int APB_ADDR_WIDTH  = REG_ADDR_LSB + REG_INDEX_WIDTH;

    typedef logic signed [DATA_WIDTH-1:0] data_t;
    typedef logic signed [DATA_WIDTH:0]   wide_t;
    typedef logic [MAG_WIDTH-1:0]         mag_t;
    typedef logic [APB_DATA_WIDTH-1:0]    apb_data_t;
    typedef logic [APB_ADDR_WIDTH-1:0]    apb_addr_t;

    localparam data_t DATA_MAX = {1'b0, {MAG_WIDTH{1'b1}}};
    localparam data_t DATA_MIN = {1'b1, {MAG_WIDTH{1'b0}}};

    typedef enum logic [REG_INDEX_WIDTH-1:0] {
        REG_STEP_LIMIT,
        REG_POSITION_MIN,
        REG_POSITION_MAX,
        REG_TORQUE_LIMIT,
        REG_SLEW_ENABLE,
        REG_TORQUE_CLIP_ENABLE,
        REG_GRIPPER_MODE,
        REG_BLOCK_TORQUE_THRESHOLD
    } reg_index_t;

    typedef struct packed {
        mag_t  step_limit;
        data_t position_min;
        data_t position_max;
        mag_t  torque_limit;
        logic  slew_enable;
        logic  torque_clip_enable;
        logic  gripper_mode;
        mag_t  block_torque_threshold;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        step_limit:             '0,
        position_min:           '0,
        position_max:           '0,
        torque_limit:           '0,
        slew_enable:            1'b1,
        torque_clip_enable:     1'b1,
        gripper_mode:           1'b0,
        block_torque_threshold: '0
    };

    typedef struct packed {
        data_t cmd_position;
        data_t cmd_velocity;
        data_t cmd_torque;
        data_t measured_position;
        data_t measured_torque;
        logic  gain_active;
    } item_t;

    typedef struct packed {
        data_t out_position;
        data_t out_velocity;
        data_t out_torque;
        logic  slew_limited;
        logic  range_clamped;
        logic  torque_clamped;
        logic  motion_held;
    } result_t;

    // sign-extend by one bit so sums and differences cannot wrap
    function automatic wide_t widen(data_t v);
        return {v[DATA_WIDTH-1], v};
    endfunction

    // zero-extend an unsigned magnitude to the wide signed form
    function automatic wide_t widen_mag(mag_t v);
        return {2'b00, v};
    endfunction

    function automatic data_t saturate(wide_t v);
        data_t r;
        if (v[DATA_WIDTH] != v[DATA_WIDTH-1])
        begin
            r = v[DATA_WIDTH] ? DATA_MIN : DATA_MAX;
        end
        else
        begin
            r = v[DATA_WIDTH-1:0];
        end
        return r;
    endfunction

    // magnitude of a wide value, read as unsigned
    function automatic logic [DATA_WIDTH:0] magnitude(wide_t v);
        logic [DATA_WIDTH:0] r;
        if (v[DATA_WIDTH])
        begin
            r = -v;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ----- rtl/jcl_regs.sv -----
// configuration register file with its apb-style access port
// depends on jcl_pkg for register indexes, widths and the cfg_t bundle
module jcl_regs (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  jcl_pkg::apb_addr_t  paddr,
    input  jcl_pkg::apb_data_t  pwdata,
    output jcl_pkg::apb_data_t  prdata,
    output logic                pready,
    output jcl_pkg::cfg_t       cfg
);
    import jcl_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    reg_index_t index;
    logic       write_en;

    assign pready   = 1'b1;
    assign write_en = psel && penable && pwrite;
    assign index    = reg_index_t'(paddr[APB_ADDR_WIDTH-1:REG_ADDR_LSB]);
    assign cfg      = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (write_en)
        begin
            case (index)
                REG_STEP_LIMIT:
                    cfg_next.step_limit = pwdata[MAG_WIDTH-1:0];
                REG_POSITION_MIN:
                    cfg_next.position_min = pwdata[DATA_WIDTH-1:0];
                REG_POSITION_MAX:
                    cfg_next.position_max = pwdata[DATA_WIDTH-1:0];
                REG_TORQUE_LIMIT:
                    cfg_next.torque_limit = pwdata[MAG_WIDTH-1:0];
                REG_SLEW_ENABLE:
                    cfg_next.slew_enable = pwdata[0];
                REG_TORQUE_CLIP_ENABLE:
                    cfg_next.torque_clip_enable = pwdata[0];
                REG_GRIPPER_MODE:
                    cfg_next.gripper_mode = pwdata[0];
                REG_BLOCK_TORQUE_THRESHOLD:
                    cfg_next.block_torque_threshold = pwdata[MAG_WIDTH-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // limits read back sign-extended, magnitudes zero-extended
    always_comb
    begin
        case (index)
            REG_STEP_LIMIT:
                prdata = APB_DATA_WIDTH'(cfg_reg.step_limit);
            REG_POSITION_MIN:
                prdata = APB_DATA_WIDTH'(cfg_reg.position_min);
            REG_POSITION_MAX:
                prdata = APB_DATA_WIDTH'(cfg_reg.position_max);
            REG_TORQUE_LIMIT:
                prdata = APB_DATA_WIDTH'(cfg_reg.torque_limit);
            REG_SLEW_ENABLE:
                prdata = APB_DATA_WIDTH'(cfg_reg.slew_enable);
            REG_TORQUE_CLIP_ENABLE:
                prdata = APB_DATA_WIDTH'(cfg_reg.torque_clip_enable);
            REG_GRIPPER_MODE:
                prdata = APB_DATA_WIDTH'(cfg_reg.gripper_mode);
            REG_BLOCK_TORQUE_THRESHOLD:
                prdata = APB_DATA_WIDTH'(cfg_reg.block_torque_threshold);
            default:
                prdata = '0;
        endcase
    end

endmodule

// ----- rtl/jcl_shaper.sv -----
// combinational command shaping: slew limit, range clamp, gripper hold, torque clamp
// depends on jcl_pkg for item, result and configuration types and helpers
module jcl_shaper (
    input  jcl_pkg::item_t   item,
    input  jcl_pkg::data_t   last_position,
    input  jcl_pkg::cfg_t    cfg,
    output jcl_pkg::result_t result
);
    import jcl_pkg::*;

    wide_t               step_diff;
    logic [DATA_WIDTH:0] step_mag;
    logic                step_too_big;
    wide_t               step_sum;
    data_t               slew_position;
    logic                slewed;
    data_t               range_position;
    logic                ranged;
    wide_t               torque_meas_w;
    logic [DATA_WIDTH:0] torque_meas_mag;
    logic                torque_blocking;
    wide_t               hold_diff;
    logic                meas_positive;
    logic                held;
    wide_t               cmd_torque_w;
    wide_t               torque_limit_w;
    data_t               torque_out;
    logic                torque_clamped;

    // slew limit against the last output position
    assign step_diff    = widen(item.cmd_position) - widen(last_position);
    assign step_mag     = magnitude(step_diff);
    assign step_too_big = step_mag > {2'b00, cfg.step_limit};
    assign step_sum     = step_diff[DATA_WIDTH]
                          ? widen(last_position) - widen_mag(cfg.step_limit)
                          : widen(last_position) + widen_mag(cfg.step_limit);

    always_comb
    begin
        slew_position = item.cmd_position;
        slewed        = 1'b0;
        if (cfg.slew_enable)
        begin
            if (item.gain_active)
            begin
                if (step_too_big)
                begin
                    slew_position = saturate(step_sum);
                    slewed        = 1'b1;
                end
            end
            else
            begin
                slew_position = item.measured_position;
            end
        end
    end

    // lower limit checked first; if inverted, values below it take it, others the upper
    always_comb
    begin
        range_position = slew_position;
        ranged         = 1'b0;
        if ($signed(slew_position) < $signed(cfg.position_min))
        begin
            range_position = cfg.position_min;
            ranged         = 1'b1;
        end
        else if ($signed(slew_position) > $signed(cfg.position_max))
        begin
            range_position = cfg.position_max;
            ranged         = 1'b1;
        end
    end

    // gripper hold: motion in the direction the measured torque pushes is stopped
    assign torque_meas_w   = widen(item.measured_torque);
    assign torque_meas_mag = magnitude(torque_meas_w);
    assign torque_blocking = torque_meas_mag > {2'b00, cfg.block_torque_threshold};
    assign hold_diff       = widen(range_position) - widen(last_position);
    assign meas_positive   = !item.measured_torque[DATA_WIDTH-1]
                             && (item.measured_torque != '0);
    assign held = cfg.gripper_mode && torque_blocking
                  && ((meas_positive && !hold_diff[DATA_WIDTH] && (hold_diff != '0))
                      || (!meas_positive && hold_diff[DATA_WIDTH]));

    // symmetric torque clamp when enabled; gripper mode forces zero torque
    assign cmd_torque_w   = widen(item.cmd_torque);
    assign torque_limit_w = widen_mag(cfg.torque_limit);

    always_comb
    begin
        torque_out     = item.cmd_torque;
        torque_clamped = 1'b0;
        if (cfg.gripper_mode)
        begin
            torque_out = '0;
        end
        else if (cfg.torque_clip_enable)
        begin
            if ($signed(cmd_torque_w) > $signed(torque_limit_w))
            begin
                torque_out     = torque_limit_w[DATA_WIDTH-1:0];
                torque_clamped = 1'b1;
            end
            else if ($signed(cmd_torque_w) < -$signed(torque_limit_w))
            begin
                torque_out     = data_t'(-torque_limit_w);
                torque_clamped = 1'b1;
            end
        end
    end

    always_comb
    begin
        result.out_position   = held ? last_position : range_position;
        result.out_velocity   = cfg.gripper_mode ? data_t'(0) : item.cmd_velocity;
        result.out_torque     = torque_out;
        result.slew_limited   = slewed;
        result.range_clamped  = ranged;
        result.torque_clamped = torque_clamped;
        result.motion_held    = held;
    end

endmodule

// ----- rtl/joint_command_limiter.sv -----
// top level of the joint command limiter: input register, shaper, result register
// depends on jcl_pkg, jcl_regs, jcl_shaper and joint_command_limiter_macros.svh
//
// An item is captured in the input register at its input transfer, shaped in a
// single combinational pass, and stored in the result register together with
// the new last output position, from which its result transfers out. The
// block accepts one item every cycle while in_stall is low; the shaper closes
// the loop through the last-position register. in_stall rises only while both
// registers hold items and out_stall is high. The user must write
// configuration over the register port only while the block is idle; the
// block itself does not enforce this.
`include "joint_command_limiter_macros.svh"

module joint_command_limiter (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  jcl_pkg::apb_addr_t  paddr,
    input  jcl_pkg::apb_data_t  pwdata,
    output jcl_pkg::apb_data_t  prdata,
    output logic                pready,
    input  logic                in_valid,
    output logic                in_stall,
    input  jcl_pkg::data_t      cmd_position,
    input  jcl_pkg::data_t      cmd_velocity,
    input  jcl_pkg::data_t      cmd_torque,
    input  jcl_pkg::data_t      measured_position,
    input  jcl_pkg::data_t      measured_torque,
    input  logic                gain_active,
    output logic                out_valid,
    input  logic                out_stall,
    output jcl_pkg::data_t      out_position,
    output jcl_pkg::data_t      out_velocity,
    output jcl_pkg::data_t      out_torque,
    output logic                slew_limited,
    output logic                range_clamped,
    output logic                torque_clamped,
    output logic                motion_held
);
    import jcl_pkg::*;

    cfg_t    cfg;
    item_t   item_reg;
    item_t   item_next;
    logic    in_valid_reg;
    logic    in_valid_next;
    result_t result_reg;
    result_t result_next;
    result_t shaped;
    logic    out_valid_reg;
    logic    out_valid_next;
    data_t   last_pos_reg;
    data_t   last_pos_next;
    logic    in_take;
    logic    advance;

    jcl_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    jcl_shaper u_shaper (
        .item          (item_reg),
        .last_position (last_pos_reg),
        .cfg           (cfg),
        .result        (shaped)
    );

    // the held item moves on whenever the result register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && out_valid_reg && out_stall;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next  = in_take || (in_valid_reg && !advance);
        out_valid_next = advance || (out_valid_reg && out_stall);
        last_pos_next  = advance ? shaped.out_position : last_pos_reg;
        result_next    = advance ? shaped : result_reg;
        if (in_take)
        begin
            item_next.cmd_position      = cmd_position;
            item_next.cmd_velocity      = cmd_velocity;
            item_next.cmd_torque        = cmd_torque;
            item_next.measured_position = measured_position;
            item_next.measured_torque   = measured_torque;
            item_next.gain_active       = gain_active;
        end
        else
        begin
            item_next = item_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            last_pos_reg  <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            last_pos_reg  <= last_pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        result_reg <= result_next;
    end

    assign out_valid      = out_valid_reg;
    assign out_position   = result_reg.out_position;
    assign out_velocity   = result_reg.out_velocity;
    assign out_torque     = result_reg.out_torque;
    assign slew_limited   = result_reg.slew_limited;
    assign range_clamped  = result_reg.range_clamped;
    assign torque_clamped = result_reg.torque_clamped;
    assign motion_held    = result_reg.motion_held;

    // the saved position always matches the latest result
    `JCL_ASSERT_IMPL(a_last_pos_tracks_result, out_valid_reg,
        last_pos_reg == result_reg.out_position)
    // stall only when both registers are occupied
    `JCL_ASSERT_IMPL(a_stall_only_when_full, in_stall, in_valid_reg && out_valid_reg)
    // a held gripper step never carries a torque command
    `JCL_ASSERT_IMPL(a_hold_zero_torque, out_valid_reg && result_reg.motion_held,
        result_reg.out_torque == '0 && !result_reg.torque_clamped)
    // a drained result register empties when nothing waits behind it
    `JCL_ASSERT_NEXT(a_drain_empties, out_valid_reg && !out_stall && !in_valid_reg,
        !out_valid_reg)

endmodule
